// ===== sv/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// Types and constants shared by the fit-policy block allocator modules.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Fixed field widths of the item beats
  localparam int unsigned IdxBits   = 3;
  localparam int unsigned SpaceBits = 16;

  // Configuration register port
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 4;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_POLICY_MODE   = 2'd0,
    CFG_BLOCKS_IN_USE = 2'd1
  } cfg_reg_e;

  // Allocation policies; the unused code behaves as first fit
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  // Item function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  localparam logic [3:0] BLOCKS_IN_USE_RST = 4'd8;

  typedef struct packed {
    logic                 func;
    logic [IdxBits-1:0]   block_index;
    logic [SpaceBits-1:0] load_space;
    logic [SpaceBits-1:0] request_size;
    logic                 end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic                 granted;
    logic [IdxBits-1:0]   chosen_block;
    logic [SpaceBits-1:0] space_left;
    logic                 batch_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0] policy_mode;
    logic [3:0] blocks_in_use;
  } cfg_t;

endpackage

// ===== sv/fpba_space_ram.sv =====
// ----------------------------------------------------------------------------
// fpba_space_ram
// Free-space store: one write port and one read port with a registered read.
// A per-entry valid bit makes entries read as zero until they are written.
// ----------------------------------------------------------------------------
module fpba_space_ram #(
  parameter int unsigned BLOCKS    = 8,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    rd_en_i,
  input  logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] rd_addr_i,
  output logic [SIZE_BITS-1:0]                    rd_data_o,
  input  logic                                    wr_en_i,
  input  logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] wr_addr_i,
  input  logic [SIZE_BITS-1:0]                    wr_data_i
);

  logic [SIZE_BITS-1:0] mem [BLOCKS];
  logic [BLOCKS-1:0]    vld_q;
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      rd_vld_q  <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== sv/fpba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: takes one item, scans the store one block per cycle for a
// request, writes the chosen or loaded block back and hands the result on.
// ----------------------------------------------------------------------------
module fpba_ctrl #(
  parameter int unsigned BLOCKS    = 8,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  fpba_pkg::cfg_t                          cfg_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  fpba_pkg::in_item_t                      in_data_i,
  output logic                                    res_valid_o,
  input  logic                                    res_ready_i,
  output fpba_pkg::out_item_t                     res_data_o,
  output logic                                    rd_en_o,
  output logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] rd_addr_o,
  input  logic [SIZE_BITS-1:0]                    rd_data_i,
  output logic                                    wr_en_o,
  output logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] wr_addr_o,
  output logic [SIZE_BITS-1:0]                    wr_data_o
);

  localparam int unsigned IdxW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(BLOCKS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  fpba_pkg::in_item_t   item_q, item_d;
  fpba_pkg::out_item_t  res_q, res_d;
  logic [CntW-1:0]      rd_cnt_q, rd_cnt_d;
  logic [CntW-1:0]      limit_q, limit_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic                 have_q, have_d;
  logic [IdxW-1:0]      pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;

  logic                 accept;
  logic                 issue;
  logic                 fits;
  logic                 take;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] req_size;
  logic [SIZE_BITS-1:0] load_val;
  logic [SIZE_BITS-1:0] remain;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign req_size = SIZE_BITS'(item_q.request_size);
  assign load_val = SIZE_BITS'(item_q.load_space);
  assign remain   = best_q - req_size;
  assign load_ok  = (32'(item_q.block_index) < 32'(BLOCKS));

  assign issue = (state_q == S_SCAN) && (rd_cnt_q < limit_q);
  assign fits  = cmp_vld_q && (rd_data_i >= req_size);

  // A later block replaces the current pick only on a strict improvement,
  // so ties stay with the lowest index.
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!have_q) begin
        take = 1'b1;
      end else if (cfg_i.policy_mode == fpba_pkg::POLICY_BEST) begin
        take = rd_data_i < best_q;
      end else if (cfg_i.policy_mode == fpba_pkg::POLICY_WORST) begin
        take = rd_data_i > best_q;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    res_d     = res_q;
    rd_cnt_d  = rd_cnt_q;
    limit_d   = limit_q;
    cmp_vld_d = issue;
    cmp_idx_d = rd_cnt_q[IdxW-1:0];
    have_d    = have_q;
    pick_d    = pick_q;
    best_d    = best_q;
    wr_en_o   = 1'b0;
    wr_addr_o = pick_q;
    wr_data_o = remain;

    if (take) begin
      have_d = 1'b1;
      pick_d = cmp_idx_q;
      best_d = rd_data_i;
    end
    if (issue) begin
      rd_cnt_d = rd_cnt_q + 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d   = in_data_i;
          rd_cnt_d = '0;
          have_d   = 1'b0;
          if (32'(cfg_i.blocks_in_use) >= 32'(BLOCKS)) begin
            limit_d = CntW'(BLOCKS);
          end else begin
            limit_d = CntW'(cfg_i.blocks_in_use);
          end
          if (in_data_i.func == fpba_pkg::FUNC_REQUEST) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_SCAN: begin
        if (!issue && !cmp_vld_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        res_d = '0;
        res_d.batch_end = item_q.end_of_batch;
        if (item_q.func == fpba_pkg::FUNC_LOAD) begin
          if (load_ok) begin
            wr_en_o          = 1'b1;
            wr_addr_o        = IdxW'(item_q.block_index);
            wr_data_o        = load_val;
            res_d.space_left = fpba_pkg::SpaceBits'(load_val);
          end
        end else if (have_q) begin
          wr_en_o            = 1'b1;
          res_d.granted      = 1'b1;
          res_d.chosen_block = fpba_pkg::IdxBits'(pick_q);
          res_d.space_left   = fpba_pkg::SpaceBits'(remain);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    res_q     <= res_d;
    rd_cnt_q  <= rd_cnt_d;
    limit_q   <= limit_d;
    cmp_idx_q <= cmp_idx_d;
    have_q    <= have_d;
    pick_q    <= pick_d;
    best_q    <= best_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_data_o  = res_q;
  assign rd_en_o     = issue;
  assign rd_addr_o   = rd_cnt_q[IdxW-1:0];

endmodule

// ===== sv/fit_policy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Keeps the free space of a set of blocks and serves allocation requests
// under a first, best or worst fit policy.
//
//   Channel   Direction   Handshake                   Beat
//   in        input       in_valid_i / in_stall_o     fpba_pkg::in_item_t
//   out       output      out_valid_o / out_stall_i   fpba_pkg::out_item_t
//   cfg       input       cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A load writes its block in the write state and then hands on its result.
// A request walks the single read port of the free-space memory one block per
// cycle over N = min(blocks_in_use, BLOCKS) blocks, then writes the pick.
// Reset empties the store at once through per-block valid bits.
// A result waiting on a stalled output does not stop the next item being taken;
// the item after that waits until the output register is free.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
  parameter int unsigned BLOCKS    = 8,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpba_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpba_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [fpba_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [fpba_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int unsigned IdxW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  fpba_pkg::cfg_t      cfg_q;
  logic                out_valid_q;
  fpba_pkg::out_item_t out_data_q;

  logic                res_valid;
  logic                res_ready;
  fpba_pkg::out_item_t res_data;

  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy_mode   <= fpba_pkg::POLICY_FIRST;
      cfg_q.blocks_in_use <= fpba_pkg::BLOCKS_IN_USE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fpba_pkg::CFG_POLICY_MODE) begin
        cfg_q.policy_mode <= cfg_data_i[1:0];
      end else if (cfg_idx_i == fpba_pkg::CFG_BLOCKS_IN_USE) begin
        cfg_q.blocks_in_use <= cfg_data_i[3:0];
      end
    end
  end

  // Output register between the sequencer and the downstream side.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  fpba_space_ram #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  fpba_ctrl #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

endmodule
